>>> design/erk_pkg.sv
// Shared types and constants for the echo ranging Kalman block.
// No dependencies; used by erk_regs, erk_ctrl, erk_dp and echo_ranging_kalman.
`timescale 1ns / 1ps

package erk_pkg;

  localparam int DIST_W     = 19;
  localparam int COV_W      = 24;
  localparam int TPC_W      = 8;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_STEPS = GAIN_BITS + 1;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int IN_W       = 8;
  localparam int OUT_W      = 40;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

  localparam logic [TPC_W-1:0]  TPC_RST   = 8'd58;
  localparam logic [DIST_W-1:0] NEAR_RST  = 19'd3840;
  localparam logic [COV_W-1:0]  MNOISE_RST = 24'd10240;
  localparam logic [COV_W-1:0]  PNOISE_RST = 24'd2560;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_TICKS_PER_CM  = 2'd0;
  localparam logic [1:0] REG_NEAR_LIMIT    = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd3;

  typedef struct packed {
    logic [TPC_W-1:0]  ticks_per_cm;
    logic [DIST_W-1:0] near_limit;
    logic [COV_W-1:0]  meas_noise;
    logic [COV_W-1:0]  process_noise;
  } cfg_t;

  typedef struct packed {
    logic tick;       // input beat accepted
    logic load;       // falling edge: load both dividers
    logic step_raw;   // one bit of the distance division
    logic step_gain;  // one bit of the gain division
    logic diff;       // saturate raw distance, form innovation
    logic mul;        // gain products
    logic commit;     // update state and result register
  } cmd_t;

  typedef struct packed {
    logic fall;
  } status_t;

endpackage

>>> design/echo_ranging_kalman.sv
// Echo pulse ranging with a scalar Kalman filter. One input beat is the echo pin
// level at one microsecond tick; a rising edge restarts the saturating tick
// counter, and each falling edge yields one result beat with the raw distance
// (ticks / ticks_per_cm), the filtered distance and a near flag, all distances in
// unsigned fixed point with FRAC_BITS fractional bits. A beat that is not a
// falling edge leaves the block ready for the next beat. A falling edge beat
// occupies the block through the accepting beat, the bit-serial distance
// divider, which runs alongside the 17-step gain divider, then the innovation,
// gain product and state update steps; the update waits further while an
// earlier result is still not taken.
// Depends on erk_pkg, erk_regs, erk_ctrl and erk_dp.
`timescale 1ns / 1ps

module echo_ranging_kalman #(
  parameter int COUNT_WIDTH = erk_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = erk_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [erk_pkg::IN_W-1:0]     s_tdata,   // [0] echo_level
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [erk_pkg::OUT_W-1:0]    m_tdata,   // [18:0] raw_distance,
                                                  // [37:19] filtered_distance,
                                                  // [38] is_near
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erk_pkg::ADDR_W-1:0]   paddr,
  input  logic [erk_pkg::DATA_W-1:0]   pwdata,
  output logic [erk_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  erk_pkg::cfg_t    cfg;
  erk_pkg::cmd_t    cmd;
  erk_pkg::status_t status;

  logic [erk_pkg::DIST_W-1:0] raw_distance;
  logic [erk_pkg::DIST_W-1:0] filtered_distance;
  logic                       is_near;

  erk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  erk_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  erk_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg),
    .echo_level        (s_tdata[0]),
    .raw_distance      (raw_distance),
    .filtered_distance (filtered_distance),
    .is_near           (is_near)
  );

  assign m_tdata = {1'b0, is_near, filtered_distance, raw_distance};

endmodule

>>> design/erk_regs.sv
// APB register file for the four configuration registers.
// Depends on erk_pkg.
`timescale 1ns / 1ps

module erk_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erk_pkg::ADDR_W-1:0]   paddr,
  input  logic [erk_pkg::DATA_W-1:0]   pwdata,
  output logic [erk_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output erk_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_cm  <= erk_pkg::TPC_RST;
      cfg.near_limit    <= erk_pkg::NEAR_RST;
      cfg.meas_noise    <= erk_pkg::MNOISE_RST;
      cfg.process_noise <= erk_pkg::PNOISE_RST;
    end else if (wr_en) begin
      case (idx)
        erk_pkg::REG_TICKS_PER_CM:  cfg.ticks_per_cm  <= pwdata[erk_pkg::TPC_W-1:0];
        erk_pkg::REG_NEAR_LIMIT:    cfg.near_limit    <= pwdata[erk_pkg::DIST_W-1:0];
        erk_pkg::REG_MEAS_NOISE:    cfg.meas_noise    <= pwdata[erk_pkg::COV_W-1:0];
        erk_pkg::REG_PROCESS_NOISE: cfg.process_noise <= pwdata[erk_pkg::COV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      erk_pkg::REG_TICKS_PER_CM:  prdata = erk_pkg::DATA_W'(cfg.ticks_per_cm);
      erk_pkg::REG_NEAR_LIMIT:    prdata = erk_pkg::DATA_W'(cfg.near_limit);
      erk_pkg::REG_MEAS_NOISE:    prdata = erk_pkg::DATA_W'(cfg.meas_noise);
      erk_pkg::REG_PROCESS_NOISE: prdata = erk_pkg::DATA_W'(cfg.process_noise);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> design/erk_ctrl.sv
// Controller: input/output handshake and sequencing of the filter update.
// Depends on erk_pkg; drives erk_dp through cmd_t, reads status_t.
`timescale 1ns / 1ps

module erk_ctrl #(
  parameter int COUNT_WIDTH = erk_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = erk_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  erk_pkg::status_t  status,
  output erk_pkg::cmd_t     cmd
);

  localparam int DW    = COUNT_WIDTH + FRAC_BITS;
  localparam int NSTEP = (DW > erk_pkg::GAIN_STEPS) ? DW : erk_pkg::GAIN_STEPS;
  localparam int CNT_W = $clog2(NSTEP + 1);

  typedef enum logic [2:0] {IDLE, DIV, DIFF, MUL, UPD} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd.tick      = s_tvalid & s_tready;
    cmd.load      = cmd.tick & status.fall;
    cmd.step_raw  = (state == DIV) && (cnt < CNT_W'(DW));
    cmd.step_gain = (state == DIV) && (cnt < CNT_W'(erk_pkg::GAIN_STEPS));
    cmd.diff      = (state == DIFF);
    cmd.mul       = (state == MUL);
    cmd.commit    = (state == UPD) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= DIV;
            cnt   <= CNT_W'(NSTEP - 1);
          end
        end
        DIV: begin
          if (cnt == '0) state <= DIFF;
          else cnt <= cnt - CNT_W'(1);
        end
        DIFF: state <= MUL;
        MUL:  state <= UPD;
        UPD: begin
          // hold until the result register is free
          if (cmd.commit) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_fall_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == DIV) else $error("falling edge did not start division");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == DIV && cnt == '0) |=> state == DIFF) else $error("division overran");

  a_valid_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == UPD)) else $error("result without update");

endmodule

>>> design/erk_dp.sv
// Datapath: edge detect, tick counter, bit-serial dividers, gain products,
// estimate and covariance registers, result register. Depends on erk_pkg.
`timescale 1ns / 1ps

module erk_dp #(
  parameter int COUNT_WIDTH = erk_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = erk_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  erk_pkg::cmd_t               cmd,
  output erk_pkg::status_t            status,
  input  erk_pkg::cfg_t               cfg,
  input  logic                        echo_level,
  output logic [erk_pkg::DIST_W-1:0]  raw_distance,
  output logic [erk_pkg::DIST_W-1:0]  filtered_distance,
  output logic                        is_near
);

  localparam int DW  = COUNT_WIDTH + FRAC_BITS;
  localparam int QW  = (DW > erk_pkg::DIST_W) ? DW : erk_pkg::DIST_W + 1;
  localparam int DSW = erk_pkg::DIST_W;
  localparam int CVW = erk_pkg::COV_W;
  localparam int GB  = erk_pkg::GAIN_BITS;
  localparam int TW  = erk_pkg::TPC_W;

  // edge and counter state
  logic                   last_echo;
  logic                   measuring;
  logic [COUNT_WIDTH-1:0] pulse_ticks;
  logic [COUNT_WIDTH-1:0] pulse_ticks_next;
  logic                   rise;

  // filter state
  logic [DSW-1:0] estimate;
  logic [CVW-1:0] error_cov;

  // distance divider: quotient shifts in as the dividend shifts out
  logic [DW-1:0]  rq;
  logic [TW-1:0]  rrem;
  logic [TW-1:0]  divisor;
  logic [TW:0]    rshift;
  logic [TW:0]    rsub;
  logic           rge;

  // gain divider
  logic [CVW+1:0] grem;
  logic [CVW:0]   den;
  logic [GB:0]    gq;
  logic           gge;
  logic [CVW+1:0] gsub;
  logic [CVW:0]   grest;

  // innovation and products
  logic [QW-1:0]  rq_ext;
  logic [DSW-1:0] raw_sat;
  logic [GB:0]    k_sel;
  logic [DSW-1:0] raw_r;
  logic           up;
  logic [DSW-1:0] diff;
  logic [GB:0]    k;
  logic [GB:0]    kc;
  logic [GB+DSW:0]   prod_e;
  logic [GB+CVW:0]   prod_p;
  logic [DSW-1:0] corr;
  logic [CVW:0]   pn;

  // update
  logic [DSW-1:0] est_new;
  logic [CVW+1:0] p_sum;
  logic [CVW-1:0] p_sat;

  assign rise        = echo_level & ~last_echo;
  assign status.fall = ~echo_level & last_echo & measuring;

  always_comb begin
    if (rise) pulse_ticks_next = '0;
    else if (measuring && pulse_ticks != '1) pulse_ticks_next = pulse_ticks + COUNT_WIDTH'(1);
    else pulse_ticks_next = pulse_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_echo   <= 1'b0;
      measuring   <= 1'b0;
      pulse_ticks <= '0;
    end else if (cmd.tick) begin
      last_echo   <= echo_level;
      pulse_ticks <= pulse_ticks_next;
      if (rise) measuring <= 1'b1;
      else if (status.fall) measuring <= 1'b0;
    end
  end

  // distance division step; a zero divisor counts as one
  assign divisor = (cfg.ticks_per_cm == '0) ? TW'(1) : cfg.ticks_per_cm;
  assign rshift  = {rrem, rq[DW-1]};
  assign rge     = rshift >= {1'b0, divisor};
  assign rsub    = rshift - {1'b0, divisor};

  // gain division step: remainder stays below den, so one compare per bit
  assign gsub  = grem - {1'b0, den};
  assign gge   = grem >= {1'b0, den};
  assign grest = gge ? gsub[CVW:0] : grem[CVW:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq   <= {pulse_ticks_next, {FRAC_BITS{1'b0}}};
      rrem <= '0;
      grem <= {2'b00, error_cov};
      den  <= {1'b0, error_cov} + {1'b0, cfg.meas_noise};
      gq   <= '0;
    end else begin
      if (cmd.step_raw) begin
        rrem <= rge ? rsub[TW-1:0] : rshift[TW-1:0];
        rq   <= {rq[DW-2:0], rge};
      end
      if (cmd.step_gain) begin
        grem <= {grest, 1'b0};
        gq   <= {gq[GB-1:0], gge};
      end
    end
  end

  assign rq_ext  = QW'(rq);
  assign raw_sat = (|rq_ext[QW-1:DSW]) ? '1 : rq_ext[DSW-1:0];
  assign k_sel   = (den == '0) ? '0 : gq;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      raw_r <= raw_sat;
      up    <= raw_sat >= estimate;
      diff  <= (raw_sat >= estimate) ? raw_sat - estimate : estimate - raw_sat;
      k     <= k_sel;
      kc    <= erk_pkg::GAIN_ONE - k_sel;
    end
  end

  assign prod_e = (GB+DSW+1)'(k) * (GB+DSW+1)'(diff);
  assign prod_p = (GB+CVW+1)'(kc) * (GB+CVW+1)'(error_cov);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      corr <= prod_e[GB +: DSW];
      pn   <= prod_p[GB +: CVW+1];
    end
  end

  assign est_new = up ? estimate + corr : estimate - corr;
  assign p_sum   = {1'b0, pn} + (CVW+2)'(cfg.process_noise);
  assign p_sat   = (|p_sum[CVW+1:CVW]) ? '1 : p_sum[CVW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate  <= '0;
      error_cov <= '0;
    end else if (cmd.commit) begin
      estimate  <= est_new;
      error_cov <= p_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      raw_distance      <= raw_r;
      filtered_distance <= est_new;
      is_near           <= est_new < cfg.near_limit;
    end
  end

  a_cov_floor: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> error_cov >= $past(cfg.process_noise))
    else $error("covariance below process noise");

  a_near_flag: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> is_near == (filtered_distance < $past(cfg.near_limit)))
    else $error("near flag disagrees with estimate");

endmodule
